@@ rtl/i2cm_pkg.sv @@
// shared types and constants for the i2c master byte engine
package i2cm_pkg;

   localparam int HALF_WIDTH   = 8;
   localparam int DELAY_WIDTH  = 8;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QADDR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int BYTE_BITS    = 8;

   localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET = HALF_WIDTH'(20);

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ST_A    = 3'd1;
   localparam logic [2:0] PH_ST_B    = 3'd2;
   localparam logic [2:0] PH_SP_A    = 3'd3;
   localparam logic [2:0] PH_SP_B    = 3'd4;
   localparam logic [2:0] PH_SP_C    = 3'd5;
   localparam logic [2:0] PH_CK_LOW  = 3'd6;
   localparam logic [2:0] PH_CK_HIGH = 3'd7;

   // registered by the front stage: command decoded to request flags, at most one set
   typedef struct packed {
      logic       sda_in;
      logic       start_req;
      logic       stop_req;
      logic       write_req;
      logic       read_req;
      logic [7:0] tx_byte;
      logic       send_nack;
   } item_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       ack_received;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

endpackage

@@ rtl/i2cm_front.sv @@
// front stage: takes requests and decodes the command
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       sda_in,
   input  logic       cmd_valid,
   input  logic [1:0] command,
   input  logic [7:0] tx_byte,
   input  logic       send_nack,
   output logic       out_valid,
   input  logic       out_ready,
   output item_type   out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in           = item_ff;
      valid_in          = valid_ff;
      if (in_ready) begin
         valid_in           = in_valid;
         item_in.sda_in     = sda_in;
         item_in.start_req  = cmd_valid && (command == CMD_START);
         item_in.stop_req   = cmd_valid && (command == CMD_STOP);
         item_in.write_req  = cmd_valid && (command == CMD_WRITE);
         item_in.read_req   = cmd_valid && (command == CMD_READ);
         item_in.tx_byte    = tx_byte;
         item_in.send_nack  = send_nack;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/i2cm_queue.sv @@
// short queue between the front and back stages
module i2cm_queue
   import i2cm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type                mem [QUEUE_DEPTH];
   logic [QADDR_WIDTH-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_WIDTH-1:0] count_ff;
   logic                    push, pop;

   assign push_ready = (count_ff != QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/i2cm_back.sv @@
// back stage: bus sequencer, one tick per request while the result side is not stalled, with registered result
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [HALF_WIDTH-1:0] csr_wr_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  item_type              in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output result_type            out_result
);

   logic [HALF_WIDTH-1:0]  half_ff;
   logic [2:0]             phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in, delay_load, delay_dec;
   logic [3:0]             bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in, rx_ff, rx_in;
   logic                   scl_ff, scl_in, sda_ff, sda_in;
   logic                   ack_ff, ack_in, nack_ff, nack_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic                   done;
   logic                   rsp_valid_ff;
   result_type             rsp_ff;
   logic                   take;

   assign in_ready = !rsp_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign delay_load = (DELAY_WIDTH'(half_ff) == '0) ? DELAY_WIDTH'(1) : DELAY_WIDTH'(half_ff);
   assign delay_dec  = (delay_ff != '0) ? delay_ff - 1'b1 : delay_ff;

   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      rx_in    = rx_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      nack_in  = nack_ff;
      cmd_in   = cmd_ff;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (in_item.start_req) begin
            cmd_in   = CMD_START;
            delay_in = delay_load;
            sda_in   = 1'b1;
            scl_in   = 1'b1;
            phase_in = PH_ST_A;
         end else if (in_item.stop_req) begin
            cmd_in   = CMD_STOP;
            delay_in = delay_load;
            sda_in   = 1'b0;
            scl_in   = 1'b0;
            phase_in = PH_SP_A;
         end else if (in_item.write_req) begin
            cmd_in   = CMD_WRITE;
            delay_in = delay_load;
            shift_in = in_item.tx_byte;
            bit_in   = '0;
            sda_in   = in_item.tx_byte[7];
            phase_in = PH_CK_LOW;
         end else if (in_item.read_req) begin
            cmd_in   = CMD_READ;
            delay_in = delay_load;
            shift_in = '0;
            bit_in   = '0;
            nack_in  = in_item.send_nack;
            sda_in   = 1'b1;
            phase_in = PH_CK_LOW;
         end
      end else if (delay_dec != '0) begin
         delay_in = delay_dec;
      end else begin
         delay_in = delay_load;
         unique case (phase_ff)
            PH_ST_A: begin
               sda_in   = 1'b0;
               phase_in = PH_ST_B;
            end
            PH_ST_B: begin
               delay_in = delay_dec;
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_SP_A: begin
               scl_in   = 1'b1;
               phase_in = PH_SP_B;
            end
            PH_SP_B: begin
               sda_in   = 1'b1;
               phase_in = PH_SP_C;
            end
            PH_CK_LOW: begin
               scl_in   = 1'b1;
               phase_in = PH_CK_HIGH;
            end
            PH_CK_HIGH: begin
               scl_in   = 1'b0;
               phase_in = PH_CK_LOW;
               if (bit_ff >= 4'(BYTE_BITS)) begin
                  // acknowledge clock finished
                  delay_in = delay_dec;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  if (cmd_ff == CMD_WRITE) begin
                     ack_in = !in_item.sda_in;
                  end else begin
                     sda_in = 1'b1;
                  end
               end else if (cmd_ff == CMD_WRITE) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 1'b1;
                  sda_in   = (bit_ff == 4'(BYTE_BITS - 1)) ? 1'b1 : shift_ff[6];
               end else begin
                  shift_in = {shift_ff[6:0], in_item.sda_in};
                  bit_in   = bit_ff + 1'b1;
                  if (bit_ff == 4'(BYTE_BITS - 1)) begin
                     rx_in  = {shift_ff[6:0], in_item.sda_in};
                     sda_in = nack_ff;
                  end
               end
            end
            default: begin
               // stop tail and any stray code end the command
               delay_in = delay_dec;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= HALF_PERIOD_RESET;
         phase_ff     <= PH_IDLE;
         delay_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         rx_ff        <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         nack_ff      <= 1'b0;
         cmd_ff       <= CMD_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
         if (take) begin
            phase_ff <= phase_in;
            delay_ff <= delay_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            rx_ff    <= rx_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            nack_ff  <= nack_in;
            cmd_ff   <= cmd_in;
         end
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff.scl_out      <= scl_in;
         rsp_ff.sda_out      <= sda_in;
         rsp_ff.busy_res     <= (phase_in != PH_IDLE);
         rsp_ff.done_res     <= done;
         rsp_ff.ack_received <= ack_in;
         rsp_ff.rx_byte      <= rx_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_ff;

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// top level of the i2c master byte engine
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: sda_in, tx_byte, send_nack; tuser: cmd_valid, command
//  rsp     | out | rsp_tvalid/tready    | tdata: scl_out, sda_out, busy, done, ack, rx_byte
//  csr     | in  | csr_wr_en            | csr_wr_data: half_period
//
// one request per clock while rsp_tready takes results, each giving exactly one result;
// path: front decode register, queue, then the sequencer's result register.
// the queue holds four requests, so the front keeps taking requests while the
// result side stalls until the queue and front register are full.
// synchronous reset clears all control state; half_period returns to 20.
module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // sda_in, tx_byte[7:0], send_nack, zeros
   input  logic [2:0]            req_tuser,   // cmd_valid, command[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // scl_out, sda_out, busy_res, done_res,
                                              // ack_received, rx_byte[7:0], zeros
   input  logic                  csr_wr_en,
   input  logic [HALF_WIDTH-1:0] csr_wr_data
);

   logic       front_valid, front_ready, back_valid, back_ready;
   item_type   front_item, back_item;
   result_type result;

   i2cm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sda_in    (req_tdata[0]),
      .cmd_valid (req_tuser[0]),
      .command   (req_tuser[2:1]),
      .tx_byte   (req_tdata[8:1]),
      .send_nack (req_tdata[9]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   i2cm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (back_valid),
      .in_ready    (back_ready),
      .in_item     (back_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = {3'b000, result.rx_byte, result.ack_received, result.done_res,
                       result.busy_res, result.sda_out, result.scl_out};

endmodule

@@ rtl/i2cm_checker.sv @@
// port-level checks for the i2c master byte engine, bound to the top level
module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a finishing tick never reports busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[2]))
      else $error("done and busy together");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // padding above the result fields stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:13] == 3'b000)
      else $error("pad bits set");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (.*);
